/* rtl/core/zyz_pkg.sv */
package zyz_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int COEF_BITS_DEF = 16;

   localparam int SERIES_TERMS = 10;
   localparam int SC_STAGES = 5 + 2 * SERIES_TERMS + 2;
   localparam int MX_STAGES = 5;
   localparam int NUM_COEF = 9;

   typedef logic signed [32:0] q31_type;
   typedef logic signed [33:0] sum_type;
   typedef logic signed [65:0] prod_type;

   localparam logic [31:0] HALF_PI_Q31 = 32'hC90F_DAA2;
   localparam q31_type Q31_ONE = 33'sh0_8000_0000;

   // Q31 x Q31 back to Q31, halves away from zero
   function automatic q31_type q31_round(input prod_type p);
      logic [65:0] mag;
      logic [65:0] rnd;
      mag = p[65] ? 66'(-p) : 66'(p);
      rnd = (mag + (66'd1 << 30)) >> 31;
      return p[65] ? -$signed(rnd[32:0]) : $signed(rnd[32:0]);
   endfunction

endpackage

/* rtl/core/zyz_if.sv */
interface zyz_req_if #(
   parameter int ANGLE_BITS = zyz_pkg::ANGLE_BITS_DEF
);
   logic valid;
   logic ready;
   logic [ANGLE_BITS-1:0] angle_a;
   logic [ANGLE_BITS-1:0] angle_b;
   logic [ANGLE_BITS-1:0] angle_g;

   modport source (output valid, output angle_a, output angle_b, output angle_g,
                   input ready);
   modport sink (input valid, input angle_a, input angle_b, input angle_g,
                 output ready);
endinterface

interface zyz_rsp_if #(
   parameter int COEF_BITS = zyz_pkg::COEF_BITS_DEF
);
   logic valid;
   logic ready;
   logic signed [COEF_BITS-1:0] r00;
   logic signed [COEF_BITS-1:0] r01;
   logic signed [COEF_BITS-1:0] r02;
   logic signed [COEF_BITS-1:0] r10;
   logic signed [COEF_BITS-1:0] r11;
   logic signed [COEF_BITS-1:0] r12;
   logic signed [COEF_BITS-1:0] r20;
   logic signed [COEF_BITS-1:0] r21;
   logic signed [COEF_BITS-1:0] r22;

   modport source (output valid, output r00, output r01, output r02, output r10,
                   output r11, output r12, output r20, output r21, output r22,
                   input ready);
   modport sink (input valid, input r00, input r01, input r02, input r10,
                 input r11, input r12, input r20, input r21, input r22,
                 output ready);
endinterface

/* rtl/core/zyz_sincos.sv */
module zyz_sincos #(
   parameter int ANGLE_BITS = zyz_pkg::ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [ANGLE_BITS-1:0] angle,
   output zyz_pkg::q31_type      sin_q,
   output zyz_pkg::q31_type      cos_q
);
   import zyz_pkg::*;

   localparam int TERMS = SERIES_TERMS;
   localparam int OCT_LEN = SC_STAGES - 1;
   localparam logic [29:0] EIGHTH = 30'h2000_0000;
   localparam bit LAST_SUB = (TERMS % 2) == 1;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   logic [31:0] turn;
   logic [29:0] frac;
   logic        swap;
   logic [29:0] r1_in, r1_ff;
   logic [2:0]  oct_in;
   logic [2:0]  oct_ff [OCT_LEN];

   logic [61:0] px_in, px_ff;
   logic [30:0] x3_in, x3_ff, x4_ff, x5_ff;
   logic [61:0] sq_in, sq_ff;
   logic [30:0] x25_in, x25_ff;

   logic [62:0] pa_s_ff [TERMS];
   logic [62:0] pa_c_ff [TERMS];
   logic [63:0] pb_s_ff [TERMS];
   logic [63:0] pb_c_ff [TERMS];
   logic [30:0] x2a_ff [TERMS];
   logic [30:0] x2b_ff [TERMS];
   q31_type     ssa_ff [TERMS];
   q31_type     csa_ff [TERMS];
   q31_type     ssb_ff [TERMS];
   q31_type     csb_ff [TERMS];
   logic [31:0] ts_w [TERMS];
   logic [31:0] tc_w [TERMS];

   q31_type  ssf_in, csf_in, ssf_ff, csf_ff;
   q31_type  s1, c1, sin_in, cos_in, sin_ff, cos_ff;
   quad_type quad;

   // fold into the first octant
   always_comb begin
      turn = 32'(angle) << (32 - ANGLE_BITS);
      frac = turn[29:0];
      swap = frac > EIGHTH;
      r1_in = swap ? 30'(31'h4000_0000 - 31'(frac)) : frac;
      oct_in = {swap, turn[31:30]};
   end

   assign px_in = 62'(r1_ff) * 62'(HALF_PI_Q31);
   assign x3_in = 31'((px_ff + (62'd1 << 29)) >> 30);
   assign sq_in = 62'(x3_ff) * 62'(x3_ff);
   assign x25_in = 31'((sq_ff + (62'd1 << 30)) >> 31);

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff <= r1_in;
         px_ff <= px_in;
         x3_ff <= x3_in;
         sq_ff <= sq_in;
         x4_ff <= x3_ff;
         x25_ff <= x25_in;
         x5_ff <= x4_ff;
         oct_ff[0] <= oct_in;
         for (int i = 1; i < OCT_LEN; i++) begin
            oct_ff[i] <= oct_ff[i-1];
         end
      end
   end

   // two stages a term: multiply by x squared, then multiply by the reciprocal of the divisor
   for (genvar k = 0; k < TERMS; k++) begin : g_term
      localparam int DS = (2 * k + 2) * (2 * k + 3);
      localparam int DC = (2 * k + 1) * (2 * k + 2);
      localparam int KS = 31 + $clog2(DS);
      localparam int KC = 31 + $clog2(DC);
      localparam logic [63:0] MS = ((64'd1 << KS) + 64'(DS - 1)) / DS;
      localparam logic [63:0] MC = ((64'd1 << KC) + 64'(DC - 1)) / DC;

      logic [31:0] ts_a, tc_a;
      logic [30:0] x2_a;
      q31_type     ss_a, cs_a;
      logic [62:0] pa_s_in, pa_c_in;
      logic [63:0] pb_s_in, pb_c_in;

      if (k == 0) begin : g_head
         assign ts_a = 32'(x5_ff);
         assign tc_a = 32'h8000_0000;
         assign x2_a = x25_ff;
         assign ss_a = $signed({2'b00, x5_ff});
         assign cs_a = Q31_ONE;
      end else begin : g_body
         localparam bit SUB = (k % 2) == 1;
         assign ts_a = ts_w[k-1];
         assign tc_a = tc_w[k-1];
         assign x2_a = x2b_ff[k-1];
         assign ss_a = SUB ? ssb_ff[k-1] - $signed({1'b0, ts_w[k-1]})
                           : ssb_ff[k-1] + $signed({1'b0, ts_w[k-1]});
         assign cs_a = SUB ? csb_ff[k-1] - $signed({1'b0, tc_w[k-1]})
                           : csb_ff[k-1] + $signed({1'b0, tc_w[k-1]});
      end

      assign pa_s_in = 63'(ts_a) * 63'(x2_a);
      assign pa_c_in = 63'(tc_a) * 63'(x2_a);
      assign pb_s_in = 64'(pa_s_ff[k][61:31]) * MS;
      assign pb_c_in = 64'(pa_c_ff[k][61:31]) * MC;
      assign ts_w[k] = 32'(pb_s_ff[k] >> KS);
      assign tc_w[k] = 32'(pb_c_ff[k] >> KC);

      always_ff @(posedge clock) begin
         if (en) begin
            pa_s_ff[k] <= pa_s_in;
            pa_c_ff[k] <= pa_c_in;
            x2a_ff[k] <= x2_a;
            ssa_ff[k] <= ss_a;
            csa_ff[k] <= cs_a;
            pb_s_ff[k] <= pb_s_in;
            pb_c_ff[k] <= pb_c_in;
            x2b_ff[k] <= x2a_ff[k];
            ssb_ff[k] <= ssa_ff[k];
            csb_ff[k] <= csa_ff[k];
         end
      end
   end

   always_comb begin
      ssf_in = LAST_SUB ? ssb_ff[TERMS-1] - $signed({1'b0, ts_w[TERMS-1]})
                        : ssb_ff[TERMS-1] + $signed({1'b0, ts_w[TERMS-1]});
      csf_in = LAST_SUB ? csb_ff[TERMS-1] - $signed({1'b0, tc_w[TERMS-1]})
                        : csb_ff[TERMS-1] + $signed({1'b0, tc_w[TERMS-1]});
   end

   // unfold octant and quadrant
   always_comb begin
      s1 = oct_ff[OCT_LEN-1][2] ? csf_ff : ssf_ff;
      c1 = oct_ff[OCT_LEN-1][2] ? ssf_ff : csf_ff;
      quad = quad_type'(oct_ff[OCT_LEN-1][1:0]);
      unique case (quad)
         QUAD_0: begin
            sin_in = s1;
            cos_in = c1;
         end
         QUAD_1: begin
            sin_in = c1;
            cos_in = -s1;
         end
         QUAD_2: begin
            sin_in = -s1;
            cos_in = -c1;
         end
         QUAD_3: begin
            sin_in = -c1;
            cos_in = s1;
         end
         default: begin
            sin_in = s1;
            cos_in = c1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ssf_ff <= ssf_in;
         csf_ff <= csf_in;
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

/* rtl/core/zyz_euler_rotation_matrix.sv */
// Throughput: one item per cycle while the skid entry is empty; the sine and cosine
// series take two stages per term (ten terms), then five stages of matrix products,
// rounding and sums.
// An output register with a one-entry skid lets input run while a result waits.
// Reset clears the valid bits, output and skid flags; data registers are not reset.
module zyz_euler_rotation_matrix #(
   parameter int ANGLE_BITS = zyz_pkg::ANGLE_BITS_DEF,
   parameter int COEF_BITS = zyz_pkg::COEF_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   zyz_req_if.sink   req_ch,
   zyz_rsp_if.source rsp_ch
);
   import zyz_pkg::*;

   localparam int PIPE_LAT = SC_STAGES + MX_STAGES;
   localparam int SH = 32 - COEF_BITS;
   localparam logic [34:0] HALF = (35'd1 << SH) >> 1;
   localparam logic signed [35:0] SAT_HI = $signed(36'((37'd1 << (COEF_BITS - 1)) - 37'd1));
   localparam logic signed [35:0] SAT_LO = -SAT_HI - 36'sd1;

   function automatic logic [COEF_BITS-1:0] to_coef(input sum_type v);
      logic [33:0]        mag;
      logic [34:0]        rnd;
      logic signed [35:0] r;
      logic signed [35:0] sat;
      mag = v[33] ? 34'(-v) : 34'(v);
      rnd = (35'(mag) + HALF) >> SH;
      r = v[33] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
      if (r > SAT_HI) begin
         sat = SAT_HI;
      end else if (r < SAT_LO) begin
         sat = SAT_LO;
      end else begin
         sat = r;
      end
      return sat[COEF_BITS-1:0];
   endfunction

   logic en;
   logic [PIPE_LAT-1:0] vld_in, vld_ff;

   q31_type sa, ca, sb, cb, sg, cg;

   prod_type t_in [2];
   prod_type t1_ff [2];
   prod_type p_in [8];
   prod_type p1_ff [8];
   q31_type  sa1_ff, ca1_ff, cb1_ff;

   q31_type  t2_ff [2];
   q31_type  p2_ff [8];
   q31_type  sa2_ff, ca2_ff, cb2_ff;

   prod_type m3_in [4];
   prod_type m3_ff [4];
   q31_type  p3_ff [8];
   q31_type  cb3_ff;

   q31_type  m4_ff [4];
   q31_type  p4_ff [8];
   q31_type  cb4_ff;

   sum_type  e_in [NUM_COEF];
   sum_type  e_ff [NUM_COEF];

   logic [NUM_COEF-1:0][COEF_BITS-1:0] res_in;
   logic [NUM_COEF-1:0][COEF_BITS-1:0] out_data_in, out_data_ff, skid_data_ff;
   logic out_vld_in, out_vld_ff, skid_vld_in, skid_vld_ff;
   logic out_load, out_from_skid, skid_load;
   logic push, take;

   assign en = ~skid_vld_ff;
   assign req_ch.ready = en;
   assign vld_in = {vld_ff[PIPE_LAT-2:0], req_ch.valid};

   zyz_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_a (
      .clock (clock),
      .en    (en),
      .angle (req_ch.angle_a),
      .sin_q (sa),
      .cos_q (ca)
   );

   zyz_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_b (
      .clock (clock),
      .en    (en),
      .angle (req_ch.angle_b),
      .sin_q (sb),
      .cos_q (cb)
   );

   zyz_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_g (
      .clock (clock),
      .en    (en),
      .angle (req_ch.angle_g),
      .sin_q (sg),
      .cos_q (cg)
   );

   always_comb begin
      t_in[0] = prod_type'(cb) * prod_type'(cg);
      t_in[1] = prod_type'(cb) * prod_type'(sg);
      p_in[0] = prod_type'(sa) * prod_type'(sg);
      p_in[1] = prod_type'(sa) * prod_type'(cg);
      p_in[2] = prod_type'(ca) * prod_type'(sb);
      p_in[3] = prod_type'(ca) * prod_type'(sg);
      p_in[4] = prod_type'(ca) * prod_type'(cg);
      p_in[5] = prod_type'(sb) * prod_type'(cg);
      p_in[6] = prod_type'(sa) * prod_type'(sb);
      p_in[7] = prod_type'(sb) * prod_type'(sg);
   end

   always_comb begin
      m3_in[0] = prod_type'(ca2_ff) * prod_type'(t2_ff[0]);
      m3_in[1] = prod_type'(ca2_ff) * prod_type'(t2_ff[1]);
      m3_in[2] = prod_type'(sa2_ff) * prod_type'(t2_ff[0]);
      m3_in[3] = prod_type'(sa2_ff) * prod_type'(t2_ff[1]);
   end

   always_comb begin
      e_in[0] = sum_type'(m4_ff[0]) - sum_type'(p4_ff[0]);
      e_in[1] = -sum_type'(m4_ff[1]) - sum_type'(p4_ff[1]);
      e_in[2] = sum_type'(p4_ff[2]);
      e_in[3] = sum_type'(m4_ff[2]) + sum_type'(p4_ff[3]);
      e_in[4] = -sum_type'(m4_ff[3]) + sum_type'(p4_ff[4]);
      e_in[5] = sum_type'(p4_ff[6]);
      e_in[6] = -sum_type'(p4_ff[5]);
      e_in[7] = sum_type'(p4_ff[7]);
      e_in[8] = sum_type'(cb4_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff <= t_in;
         p1_ff <= p_in;
         sa1_ff <= sa;
         ca1_ff <= ca;
         cb1_ff <= cb;
         for (int i = 0; i < 2; i++) begin
            t2_ff[i] <= q31_round(t1_ff[i]);
         end
         for (int i = 0; i < 8; i++) begin
            p2_ff[i] <= q31_round(p1_ff[i]);
         end
         sa2_ff <= sa1_ff;
         ca2_ff <= ca1_ff;
         cb2_ff <= cb1_ff;
         m3_ff <= m3_in;
         p3_ff <= p2_ff;
         cb3_ff <= cb2_ff;
         for (int i = 0; i < 4; i++) begin
            m4_ff[i] <= q31_round(m3_ff[i]);
         end
         p4_ff <= p3_ff;
         cb4_ff <= cb3_ff;
         e_ff <= e_in;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_COEF; i++) begin
         res_in[i] = to_coef(e_ff[i]);
      end
   end

   assign push = en & vld_ff[PIPE_LAT-1];
   assign take = out_vld_ff & rsp_ch.ready;

   always_comb begin
      out_vld_in = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_load = 1'b0;
      out_from_skid = 1'b0;
      skid_load = 1'b0;
      priority if (skid_vld_ff) begin
         if (take) begin
            out_load = 1'b1;
            out_from_skid = 1'b1;
            skid_vld_in = 1'b0;
         end
      end else if (push) begin
         if (!out_vld_ff || take) begin
            out_load = 1'b1;
            out_vld_in = 1'b1;
         end else begin
            skid_load = 1'b1;
            skid_vld_in = 1'b1;
         end
      end else if (take) begin
         out_vld_in = 1'b0;
      end
      out_data_in = out_from_skid ? skid_data_ff : res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= vld_in;
         end
         out_vld_ff <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= out_data_in;
      end
      if (skid_load) begin
         skid_data_ff <= res_in;
      end
   end

   assign rsp_ch.valid = out_vld_ff;
   assign rsp_ch.r00 = out_data_ff[0];
   assign rsp_ch.r01 = out_data_ff[1];
   assign rsp_ch.r02 = out_data_ff[2];
   assign rsp_ch.r10 = out_data_ff[3];
   assign rsp_ch.r11 = out_data_ff[4];
   assign rsp_ch.r12 = out_data_ff[5];
   assign rsp_ch.r20 = out_data_ff[6];
   assign rsp_ch.r21 = out_data_ff[7];
   assign rsp_ch.r22 = out_data_ff[8];

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds an item while the output register is empty");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push |=> out_vld_ff)
      else $error("item leaving the pipeline was dropped");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && !rsp_ch.ready) |=> (skid_vld_ff && $stable(skid_data_ff)))
      else $error("skid item lost or changed while stalled");

   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SC_STAGES-1] |-> (ca <= Q31_ONE && ca >= -Q31_ONE && cb <= Q31_ONE &&
                               cb >= -Q31_ONE && cg <= Q31_ONE && cg >= -Q31_ONE))
      else $error("cosine outside unit range");

endmodule
